>>> sv/vec3_pkg.sv
package vec3_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int CMD_BITS      = 4;
    localparam int LANES         = 3;
    localparam int WIDE_BITS     = 2 * WORD_BITS;
    localparam int SUM_BITS      = WIDE_BITS + 2;
    localparam int ROOT_STEPS    = WORD_BITS;
    localparam int QUOT_BITS     = WORD_BITS;
    localparam int SEARCH_STEPS  = 5;
    localparam int SHIFT_BITS    = SEARCH_STEPS;
    localparam int AMT_BITS      = 6;
    localparam int IN_DATA_BITS  = ((CMD_BITS + 7 * WORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 4 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS-1:0]        uword_t;
    typedef logic [WIDE_BITS-1:0]        wide_t;
    typedef logic signed [WIDE_BITS-1:0] prod_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;
    typedef logic [SHIFT_BITS-1:0]       shift_t;
    typedef wide_t  [LANES-1:0]          wide3_t;
    typedef uword_t [LANES-1:0]          uword3_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_SCALE = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_DOT   = 4'd4,
        CMD_SQMAG = 4'd5,
        CMD_MAG   = 4'd6,
        CMD_CROSS = 4'd7,
        CMD_NORM  = 4'd8
    } cmd_t;

    typedef struct packed {
        logic [CMD_BITS-1:0] command;
        word_t               ax;
        word_t               ay;
        word_t               az;
        word_t               bx;
        word_t               by;
        word_t               bz;
        word_t               scalar;
    } item_t;

    // Everything an item carries down the pipeline besides the arithmetic in flight.
    typedef struct packed {
        logic [CMD_BITS-1:0] command;
        logic                error;
        word_t               rx;
        word_t               ry;
        word_t               rz;
        word_t               scalar_out;
        uword3_t             mag_a;
        logic [LANES-1:0]    neg;
        uword_t              mag_s;
    } ctx_t;

    localparam word_t WORD_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN   = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam sum_t  ROUND_HALF = sum_t'(1) <<< (FRAC_BITS - 1);

    function automatic word_t sat_word(input sum_t v);
        sum_t hi;
        sum_t lo;
        hi = sum_t'(WORD_MAX);
        lo = sum_t'(WORD_MIN);
        if (v > hi)
            return WORD_MAX;
        else if (v < lo)
            return WORD_MIN;
        else
            return v[WORD_BITS-1:0];
    endfunction

    function automatic uword_t uabs(input word_t v);
        return v[WORD_BITS-1] ? uword_t'(-v) : uword_t'(v);
    endfunction

endpackage

>>> sv/vec3_front.sv
module vec3_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  vec3_pkg::item_t  in_item,
    output logic             out_valid,
    output vec3_pkg::ctx_t   out_ctx,
    output vec3_pkg::wide_t  out_sq
);

    localparam int LANES = vec3_pkg::LANES;

    logic               v1_reg;
    vec3_pkg::item_t    it1_reg;

    vec3_pkg::word_t    a [LANES];
    vec3_pkg::word_t    b [LANES];
    vec3_pkg::word_t    ma0 [LANES];
    vec3_pkg::word_t    ma1 [LANES];
    vec3_pkg::word_t    mb0 [LANES];
    vec3_pkg::word_t    mb1 [LANES];
    vec3_pkg::word_t    r2 [LANES];
    vec3_pkg::prod_t    pa_next [LANES];
    vec3_pkg::prod_t    pb_next [LANES];
    vec3_pkg::ctx_t     c2_next;

    logic               v2_reg;
    vec3_pkg::prod_t    pa_reg [LANES];
    vec3_pkg::prod_t    pb_reg [LANES];
    vec3_pkg::ctx_t     c2_reg;

    vec3_pkg::sum_t     l3_next [LANES];
    vec3_pkg::sum_t     t3_next;
    logic               v3_reg;
    vec3_pkg::sum_t     l3_reg [LANES];
    vec3_pkg::sum_t     t3_reg;
    vec3_pkg::ctx_t     c3_reg;

    vec3_pkg::word_t    lane_r [LANES];
    vec3_pkg::word_t    tot_r;
    vec3_pkg::ctx_t     c4_next;
    logic               v4_reg;
    vec3_pkg::ctx_t     c4_reg;
    vec3_pkg::wide_t    sq4_reg;

    assign a[0] = it1_reg.ax;
    assign a[1] = it1_reg.ay;
    assign a[2] = it1_reg.az;
    assign b[0] = it1_reg.bx;
    assign b[1] = it1_reg.by;
    assign b[2] = it1_reg.bz;

    // Operand selection and the six multipliers.
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            ma0[j] = '0;
            ma1[j] = '0;
            mb0[j] = '0;
            mb1[j] = '0;
            case (it1_reg.command)
                vec3_pkg::CMD_SCALE:
                begin
                    ma0[j] = a[j];
                    ma1[j] = it1_reg.scalar;
                end
                vec3_pkg::CMD_DOT:
                begin
                    ma0[j] = a[j];
                    ma1[j] = b[j];
                end
                vec3_pkg::CMD_SQMAG, vec3_pkg::CMD_MAG, vec3_pkg::CMD_NORM:
                begin
                    ma0[j] = a[j];
                    ma1[j] = a[j];
                end
                vec3_pkg::CMD_CROSS:
                begin
                    ma0[j] = a[(j + 1) % LANES];
                    ma1[j] = b[(j + 2) % LANES];
                    mb0[j] = a[(j + 2) % LANES];
                    mb1[j] = b[(j + 1) % LANES];
                end
                default:
                begin
                end
            endcase
            pa_next[j] = ma0[j] * ma1[j];
            pb_next[j] = mb0[j] * mb1[j];
        end
    end

    // Add and subtract finish here; the context for the long operations is set up.
    always_comb
    begin
        c2_next         = '0;
        c2_next.command = it1_reg.command;
        c2_next.mag_s   = vec3_pkg::uabs(it1_reg.scalar);
        c2_next.error   = (it1_reg.command == vec3_pkg::CMD_DIV) && (it1_reg.scalar == '0);
        for (int j = 0; j < LANES; j++)
        begin
            c2_next.mag_a[j] = vec3_pkg::uabs(a[j]);
            c2_next.neg[j]   = a[j][vec3_pkg::WORD_BITS-1]
                             ^ ((it1_reg.command == vec3_pkg::CMD_DIV)
                                & it1_reg.scalar[vec3_pkg::WORD_BITS-1]);
            case (it1_reg.command)
                vec3_pkg::CMD_ADD:
                    r2[j] = vec3_pkg::sat_word(vec3_pkg::sum_t'(a[j]) + vec3_pkg::sum_t'(b[j]));
                vec3_pkg::CMD_SUB:
                    r2[j] = vec3_pkg::sat_word(vec3_pkg::sum_t'(a[j]) - vec3_pkg::sum_t'(b[j]));
                default:
                    r2[j] = '0;
            endcase
        end
        c2_next.rx = r2[0];
        c2_next.ry = r2[1];
        c2_next.rz = r2[2];
    end

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            l3_next[j] = vec3_pkg::sum_t'(pa_reg[j]) - vec3_pkg::sum_t'(pb_reg[j])
                       + vec3_pkg::ROUND_HALF;
        end
        t3_next = vec3_pkg::sum_t'(pa_reg[0]) + vec3_pkg::sum_t'(pa_reg[1])
                + vec3_pkg::sum_t'(pa_reg[2]);
    end

    // Rounding to nearest with ties upward is a floor after adding one half.
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            lane_r[j] = vec3_pkg::sat_word(l3_reg[j] >>> vec3_pkg::FRAC_BITS);
        end
        tot_r   = vec3_pkg::sat_word((t3_reg + vec3_pkg::ROUND_HALF) >>> vec3_pkg::FRAC_BITS);
        c4_next = c3_reg;
        case (c3_reg.command)
            vec3_pkg::CMD_SCALE, vec3_pkg::CMD_CROSS:
            begin
                c4_next.rx = lane_r[0];
                c4_next.ry = lane_r[1];
                c4_next.rz = lane_r[2];
            end
            vec3_pkg::CMD_DOT, vec3_pkg::CMD_SQMAG:
                c4_next.scalar_out = tot_r;
            vec3_pkg::CMD_NORM:
                c4_next.error = (t3_reg == '0);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg <= in_item;
            c2_reg  <= c2_next;
            c3_reg  <= c2_reg;
            t3_reg  <= t3_next;
            c4_reg  <= c4_next;
            sq4_reg <= vec3_pkg::wide_t'(t3_reg);
            for (int j = 0; j < LANES; j++)
            begin
                pa_reg[j] <= pa_next[j];
                pb_reg[j] <= pb_next[j];
                l3_reg[j] <= l3_next[j];
            end
        end
    end

    assign out_valid = v4_reg;
    assign out_ctx   = c4_reg;
    assign out_sq    = sq4_reg;

endmodule

>>> sv/vec3_root.sv
module vec3_root (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  vec3_pkg::ctx_t     in_ctx,
    input  vec3_pkg::wide_t    in_sq,
    output logic               out_valid,
    output vec3_pkg::ctx_t     out_ctx,
    output vec3_pkg::uword_t   out_root,
    output vec3_pkg::shift_t   out_shift
);

    localparam int STEPS = vec3_pkg::SEARCH_STEPS;
    localparam int ROOTS = vec3_pkg::ROOT_STEPS;
    localparam int WIDE  = vec3_pkg::WIDE_BITS;

    logic               srch_v_reg   [STEPS];
    vec3_pkg::ctx_t     srch_ctx_reg [STEPS];
    vec3_pkg::wide_t    srch_x_reg   [STEPS];
    vec3_pkg::shift_t   srch_k_reg   [STEPS];

    logic               root_v_reg   [ROOTS];
    vec3_pkg::ctx_t     root_ctx_reg [ROOTS];
    vec3_pkg::wide_t    root_rem_reg [ROOTS];
    vec3_pkg::wide_t    root_res_reg [ROOTS];
    vec3_pkg::shift_t   root_k_reg   [ROOTS];

    logic               out_v_reg;
    vec3_pkg::ctx_t     out_ctx_reg;
    vec3_pkg::uword_t   out_root_reg;
    vec3_pkg::shift_t   out_k_reg;

    // Binary search for the largest even shift that keeps the square sum below 2^62.
    // Only normalize uses the shift; magnitude takes the root of the plain sum.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_search
        localparam int STEP = (1 << (STEPS - 1)) >> i;

        logic               v_in;
        vec3_pkg::ctx_t     c_in;
        vec3_pkg::wide_t    x_in;
        vec3_pkg::shift_t   k_in;
        logic               fit;

        if (i == 0)
        begin : g_head
            assign v_in = in_valid;
            assign c_in = in_ctx;
            assign x_in = in_sq;
            assign k_in = '0;
        end
        else
        begin : g_tail
            assign v_in = srch_v_reg[i-1];
            assign c_in = srch_ctx_reg[i-1];
            assign x_in = srch_x_reg[i-1];
            assign k_in = srch_k_reg[i-1];
        end

        assign fit = (c_in.command == vec3_pkg::CMD_NORM)
                  && ((x_in >> (WIDE - 2 - 2 * STEP)) == '0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                srch_v_reg[i] <= 1'b0;
            else if (en)
                srch_v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srch_ctx_reg[i] <= c_in;
                srch_x_reg[i]   <= fit ? (x_in << (2 * STEP)) : x_in;
                srch_k_reg[i]   <= fit ? (k_in + vec3_pkg::shift_t'(STEP)) : k_in;
            end
        end
    end

    // One result bit per stage, digit by digit.
    for (genvar i = 0; i < ROOTS; i++)
    begin : g_root
        localparam vec3_pkg::wide_t BIT = vec3_pkg::wide_t'(1) << (WIDE - 2 - 2 * i);

        logic               v_in;
        vec3_pkg::ctx_t     c_in;
        vec3_pkg::wide_t    rem_in;
        vec3_pkg::wide_t    res_in;
        vec3_pkg::shift_t   k_in;
        vec3_pkg::wide_t    trial;
        logic               take;

        if (i == 0)
        begin : g_head
            assign v_in   = srch_v_reg[STEPS-1];
            assign c_in   = srch_ctx_reg[STEPS-1];
            assign rem_in = srch_x_reg[STEPS-1];
            assign res_in = '0;
            assign k_in   = srch_k_reg[STEPS-1];
        end
        else
        begin : g_tail
            assign v_in   = root_v_reg[i-1];
            assign c_in   = root_ctx_reg[i-1];
            assign rem_in = root_rem_reg[i-1];
            assign res_in = root_res_reg[i-1];
            assign k_in   = root_k_reg[i-1];
        end

        assign trial = res_in + BIT;
        assign take  = (rem_in >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                root_v_reg[i] <= 1'b0;
            else if (en)
                root_v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_ctx_reg[i] <= c_in;
                root_k_reg[i]   <= k_in;
                root_rem_reg[i] <= take ? (rem_in - trial) : rem_in;
                root_res_reg[i] <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
            end
        end
    end

    // The remainder is n - r*r, so rounding up is needed when it exceeds r.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= root_v_reg[ROOTS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ctx_reg  <= root_ctx_reg[ROOTS-1];
            out_k_reg    <= root_k_reg[ROOTS-1];
            out_root_reg <= vec3_pkg::uword_t'(root_res_reg[ROOTS-1]
                          + vec3_pkg::wide_t'(root_rem_reg[ROOTS-1] > root_res_reg[ROOTS-1]));
        end
    end

    assign out_valid = out_v_reg;
    assign out_ctx   = out_ctx_reg;
    assign out_root  = out_root_reg;
    assign out_shift = out_k_reg;

endmodule

>>> sv/vec3_div.sv
module vec3_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  vec3_pkg::ctx_t            in_ctx,
    input  vec3_pkg::wide3_t          in_num,
    input  vec3_pkg::uword_t          in_den,
    output logic                      out_valid,
    output vec3_pkg::ctx_t            out_ctx,
    output vec3_pkg::uword3_t         out_quot,
    output logic [vec3_pkg::LANES-1:0] out_ovf
);

    localparam int LANES = vec3_pkg::LANES;
    localparam int QB    = vec3_pkg::QUOT_BITS;

    logic                 pre_v_reg;
    vec3_pkg::ctx_t       pre_ctx_reg;
    vec3_pkg::wide3_t     pre_r_reg;
    vec3_pkg::uword_t     pre_den_reg;
    logic [LANES-1:0]     pre_ovf_reg;
    logic [LANES-1:0]     pre_ovf_next;

    logic                 div_v_reg   [QB];
    vec3_pkg::ctx_t       div_ctx_reg [QB];
    vec3_pkg::wide3_t     div_r_reg   [QB];
    vec3_pkg::uword3_t    div_q_reg   [QB];
    vec3_pkg::uword_t     div_den_reg [QB];
    logic [LANES-1:0]     div_ovf_reg [QB];

    // A quotient that needs more than a word's bits saturates anyway.
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            pre_ovf_next[j] = (in_num[j] >= {in_den, {vec3_pkg::WORD_BITS{1'b0}}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_v_reg <= 1'b0;
        else if (en)
            pre_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_ctx_reg <= in_ctx;
            pre_r_reg   <= in_num;
            pre_den_reg <= in_den;
            pre_ovf_reg <= pre_ovf_next;
        end
    end

    // Restoring division, one quotient bit per stage, three lanes sharing a divisor.
    for (genvar i = 0; i < QB; i++)
    begin : g_quot
        localparam int B = QB - 1 - i;

        logic                 v_in;
        vec3_pkg::ctx_t       c_in;
        vec3_pkg::wide3_t     r_in;
        vec3_pkg::uword3_t    q_in;
        vec3_pkg::uword_t     den_in;
        logic [LANES-1:0]     ovf_in;
        vec3_pkg::wide_t      d_sh;
        vec3_pkg::wide3_t     r_next;
        vec3_pkg::uword3_t    q_next;

        if (i == 0)
        begin : g_head
            assign v_in   = pre_v_reg;
            assign c_in   = pre_ctx_reg;
            assign r_in   = pre_r_reg;
            assign q_in   = '0;
            assign den_in = pre_den_reg;
            assign ovf_in = pre_ovf_reg;
        end
        else
        begin : g_tail
            assign v_in   = div_v_reg[i-1];
            assign c_in   = div_ctx_reg[i-1];
            assign r_in   = div_r_reg[i-1];
            assign q_in   = div_q_reg[i-1];
            assign den_in = div_den_reg[i-1];
            assign ovf_in = div_ovf_reg[i-1];
        end

        assign d_sh = vec3_pkg::wide_t'(den_in) << B;

        always_comb
        begin
            r_next = r_in;
            q_next = q_in;
            for (int j = 0; j < LANES; j++)
            begin
                if (r_in[j] >= d_sh)
                begin
                    r_next[j]    = r_in[j] - d_sh;
                    q_next[j][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_v_reg[i] <= 1'b0;
            else if (en)
                div_v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_ctx_reg[i] <= c_in;
                div_r_reg[i]   <= r_next;
                div_q_reg[i]   <= q_next;
                div_den_reg[i] <= den_in;
                div_ovf_reg[i] <= ovf_in;
            end
        end
    end

    assign out_valid = div_v_reg[QB-1];
    assign out_ctx   = div_ctx_reg[QB-1];
    assign out_quot  = div_q_reg[QB-1];
    assign out_ovf   = div_ovf_reg[QB-1];

endmodule

>>> sv/vector3_arith_unit.sv
// Channel  Dir  tdata bits  Fields, lowest first
// s_axis   in   232         command[3:0], ax, ay, az, bx, by, bz, scalar
// m_axis   out  128         rx, ry, rz, scalar_out; tuser[0] = error
//
// One transaction per cycle while m_axis is not stalled; every command takes the same path.
// The depth comes from the 32-stage square root pipeline and the 32-stage
// quotient pipeline that all items pass through.
// Reset clears only the valid bits of the stages.
// While a result waits on m_axis, the whole pipeline holds and s_axis_tready is low.
module vector3_arith_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // command, ax, ay, az, bx, by, bz, scalar
    input  logic [vec3_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // rx, ry, rz, scalar_out
    output logic [vec3_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // error
    output logic [0:0]                          m_axis_tuser
);

    localparam int LANES = vec3_pkg::LANES;
    localparam int WB    = vec3_pkg::WORD_BITS;
    localparam int CB    = vec3_pkg::CMD_BITS;

    logic                    advance;
    vec3_pkg::item_t         in_item;

    logic                    fr_valid;
    vec3_pkg::ctx_t          fr_ctx;
    vec3_pkg::wide_t         fr_sq;

    logic                    rt_valid;
    vec3_pkg::ctx_t          rt_ctx;
    vec3_pkg::uword_t        rt_root;
    vec3_pkg::shift_t        rt_shift;

    logic                    rt_norm;
    vec3_pkg::uword_t        prep_den_next;
    logic [vec3_pkg::AMT_BITS-1:0] prep_amt;
    vec3_pkg::wide3_t        prep_num_next;
    vec3_pkg::ctx_t          prep_ctx_next;
    logic                    prep_v_reg;
    vec3_pkg::ctx_t          prep_ctx_reg;
    vec3_pkg::wide3_t        prep_num_reg;
    vec3_pkg::uword_t        prep_den_reg;

    logic                    dv_valid;
    vec3_pkg::ctx_t          dv_ctx;
    vec3_pkg::uword3_t       dv_quot;
    logic [LANES-1:0]        dv_ovf;

    vec3_pkg::word_t         q_sat [LANES];
    vec3_pkg::word_t         fin_r [LANES];
    logic                    m_v_reg;
    logic [vec3_pkg::OUT_DATA_BITS-1:0] m_data_reg;
    logic                    m_err_reg;

    assign advance       = !m_v_reg || m_axis_tready;
    assign s_axis_tready = advance;

    assign in_item.command = s_axis_tdata[CB-1:0];
    assign in_item.ax      = s_axis_tdata[CB + 0 * WB +: WB];
    assign in_item.ay      = s_axis_tdata[CB + 1 * WB +: WB];
    assign in_item.az      = s_axis_tdata[CB + 2 * WB +: WB];
    assign in_item.bx      = s_axis_tdata[CB + 3 * WB +: WB];
    assign in_item.by      = s_axis_tdata[CB + 4 * WB +: WB];
    assign in_item.bz      = s_axis_tdata[CB + 5 * WB +: WB];
    assign in_item.scalar  = s_axis_tdata[CB + 6 * WB +: WB];

    vec3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s_axis_tvalid),
        .in_item   (in_item),
        .out_valid (fr_valid),
        .out_ctx   (fr_ctx),
        .out_sq    (fr_sq)
    );

    vec3_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (fr_valid),
        .in_ctx    (fr_ctx),
        .in_sq     (fr_sq),
        .out_valid (rt_valid),
        .out_ctx   (rt_ctx),
        .out_root  (rt_root),
        .out_shift (rt_shift)
    );

    // Dividend setup: |a| scaled by the fraction bits plus the normalize shift,
    // with half the divisor added so the quotient rounds to nearest.
    always_comb
    begin
        rt_norm       = (rt_ctx.command == vec3_pkg::CMD_NORM);
        prep_den_next = rt_norm ? rt_root : rt_ctx.mag_s;
        prep_amt      = vec3_pkg::AMT_BITS'(vec3_pkg::FRAC_BITS)
                      + (rt_norm ? vec3_pkg::AMT_BITS'(rt_shift) : '0);
        for (int j = 0; j < LANES; j++)
        begin
            prep_num_next[j] = (vec3_pkg::wide_t'(rt_ctx.mag_a[j]) << prep_amt)
                             + vec3_pkg::wide_t'(prep_den_next >> 1);
        end
        prep_ctx_next = rt_ctx;
        if (rt_ctx.command == vec3_pkg::CMD_MAG)
        begin
            prep_ctx_next.scalar_out = (rt_root > vec3_pkg::uword_t'(vec3_pkg::WORD_MAX))
                                     ? vec3_pkg::WORD_MAX : vec3_pkg::word_t'(rt_root);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_v_reg <= 1'b0;
        else if (advance)
            prep_v_reg <= rt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prep_ctx_reg <= prep_ctx_next;
            prep_num_reg <= prep_num_next;
            prep_den_reg <= prep_den_next;
        end
    end

    vec3_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (prep_v_reg),
        .in_ctx    (prep_ctx_reg),
        .in_num    (prep_num_reg),
        .in_den    (prep_den_reg),
        .out_valid (dv_valid),
        .out_ctx   (dv_ctx),
        .out_quot  (dv_quot),
        .out_ovf   (dv_ovf)
    );

    // Apply the sign to the quotient magnitude and saturate.
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            if (dv_ctx.neg[j])
                q_sat[j] = (dv_ovf[j] || (dv_quot[j] > vec3_pkg::uword_t'(vec3_pkg::WORD_MIN)))
                         ? vec3_pkg::WORD_MIN : vec3_pkg::word_t'(~dv_quot[j] + 1'b1);
            else
                q_sat[j] = (dv_ovf[j] || (dv_quot[j] > vec3_pkg::uword_t'(vec3_pkg::WORD_MAX)))
                         ? vec3_pkg::WORD_MAX : vec3_pkg::word_t'(dv_quot[j]);
        end
        fin_r[0] = dv_ctx.rx;
        fin_r[1] = dv_ctx.ry;
        fin_r[2] = dv_ctx.rz;
        case (dv_ctx.command)
            vec3_pkg::CMD_DIV, vec3_pkg::CMD_NORM:
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    fin_r[j] = dv_ctx.error ? '0 : q_sat[j];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else if (advance)
            m_v_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_data_reg <= {dv_ctx.scalar_out, fin_r[2], fin_r[1], fin_r[0]};
            m_err_reg  <= dv_ctx.error;
        end
    end

    assign m_axis_tvalid   = m_v_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_err_reg;

`ifndef SYNTHESIS
    // A flagged result carries all-zero data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("error result with nonzero data");

    // A held result freezes the pipeline, so no new transaction may enter.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // Only divide and normalize can raise the error flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid && dv_ctx.error |->
            (dv_ctx.command == vec3_pkg::CMD_DIV) || (dv_ctx.command == vec3_pkg::CMD_NORM))
        else $error("error flag on a command that cannot fail");
`endif

endmodule
